// ----- design/cmas_pkg.sv -----
// cmas_pkg: shared types, schedule constants and helpers for the cubic map attractor step
package cmas_pkg;

    localparam int TERMS_PER_AXIS = 20;
    localparam int AXES           = 3;
    localparam int TABLE_DEPTH    = AXES * TERMS_PER_AXIS;
    localparam int COEFF_ADDR_W   = $clog2(TABLE_DEPTH);
    localparam int COORD_W        = 32;
    localparam int COUNT_W        = 16;
    localparam int RADIUS_W       = 31;
    localparam int CFG_INDEX_W    = 1;

    // issue schedule of the shared multiplier, one slot per cycle
    localparam int MONO_FIRST = 4;
    localparam int MONO_COUNT = TERMS_PER_AXIS - MONO_FIRST;
    localparam int MAC_FIRST  = MONO_COUNT;
    localparam int MAC_COUNT  = TABLE_DEPTH;
    localparam int RADSQ_AT   = MAC_FIRST + MAC_COUNT;
    localparam int SQ_FIRST   = RADSQ_AT + 1;
    localparam int SQ_LAST    = SQ_FIRST + AXES - 1;
    localparam int RUN_LAST   = SQ_LAST + 2;
    localparam int CNT_W      = $clog2(RUN_LAST + 1);

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [1:0] {
        ACT_WRITE,
        ACT_START,
        ACT_STEP
    } act_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ITERATION_COUNT,
        REG_ESCAPE_RADIUS
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MONO,
        OP_MAC,
        OP_RADSQ,
        OP_SQ
    } op_t;

    typedef enum logic [4:0] {
        MONO_ONE, MONO_X, MONO_Y, MONO_Z,
        MONO_XY, MONO_XZ, MONO_YZ,
        MONO_XX, MONO_YY, MONO_ZZ,
        MONO_XYZ, MONO_XXY, MONO_XXZ, MONO_YYX, MONO_YYZ,
        MONO_ZZX, MONO_ZZY, MONO_XXX, MONO_YYY, MONO_ZZZ
    } mono_t;

    typedef struct packed {
        op_t        op;
        mono_t      k;
        logic [1:0] axis;
    } mul_tag_t;

    typedef struct packed {
        mul_tag_t             tag;
        logic                 coeff_write;
        logic                 start_load;
        logic                 finish;
        logic                 escaped;
        logic                 last;
        logic [COUNT_W-1:0]   step_number;
    } ctl_t;

    typedef struct packed {
        logic escape;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [1:0]                 action;
        logic [COEFF_ADDR_W-1:0]    coeff_index;
        logic signed [COORD_W-1:0]  coeff_value;
        logic signed [COORD_W-1:0]  start_x;
        logic signed [COORD_W-1:0]  start_y;
        logic signed [COORD_W-1:0]  start_z;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
        logic signed [COORD_W-1:0]  point_z;
        logic                       escaped;
        logic                       last;
        logic [COUNT_W-1:0]         step_number;
    } out_item_t;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[COORD_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[COORD_W-1:0];
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/cmas_stream_if.sv -----
// cmas_stream_if: valid/ready channel carrying one payload beat
interface cmas_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/cmas_ram.sv -----
// cmas_ram: single write port, single registered read port RAM
module cmas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/cmas_ctrl.sv -----
// cmas_ctrl: run controller, multiplier issue schedule and step bookkeeping
module cmas_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    cmas_stream_if.sink                          cmd,
    input  logic                                 cfg_we,
    input  logic [cmas_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cmas_pkg::RADIUS_W-1:0]        cfg_data,
    input  cmas_pkg::status_t                    status,
    output cmas_pkg::ctl_t                       ctl
);

    localparam int CW = cmas_pkg::CNT_W;
    localparam int T  = cmas_pkg::TERMS_PER_AXIS;

    cmas_pkg::state_t               state_reg, state_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [cmas_pkg::COUNT_W-1:0]   step_cnt_reg;
    logic [cmas_pkg::COUNT_W-1:0]   iter_count_reg;
    logic                           run_finished_reg;
    logic                           escape_seen_reg;
    logic [CW-1:0]                  mac_idx;
    logic [CW-1:0]                  mac_rem;
    logic [1:0]                     mac_axis;
    logic                           step_item;

    assign step_item = cmd.valid && (cmd.data.action == cmas_pkg::ACT_STEP);
    assign mac_idx   = cnt_reg - CW'(cmas_pkg::MAC_FIRST);

    // split the coefficient slot into axis and monomial number
    always_comb
    begin
        if (mac_idx < CW'(T))
        begin
            mac_axis = 2'd0;
            mac_rem  = mac_idx;
        end
        else if (mac_idx < CW'(2 * T))
        begin
            mac_axis = 2'd1;
            mac_rem  = mac_idx - CW'(T);
        end
        else
        begin
            mac_axis = 2'd2;
            mac_rem  = mac_idx - CW'(2 * T);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cmas_pkg::ST_IDLE:
            begin
                if (step_item && !run_finished_reg)
                begin
                    state_next = cmas_pkg::ST_RUN;
                end
            end
            cmas_pkg::ST_RUN:
            begin
                if (cnt_reg == CW'(cmas_pkg::RUN_LAST))
                begin
                    state_next = cmas_pkg::ST_DONE;
                end
            end
            cmas_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = cmas_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cmas_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.ready   = 1'b0;
        ctl         = '0;
        ctl.tag.op  = cmas_pkg::OP_NONE;
        ctl.tag.k   = cmas_pkg::MONO_ONE;
        cnt_next    = '0;
        case (state_reg)
            cmas_pkg::ST_IDLE:
            begin
                cmd.ready       = 1'b1;
                ctl.coeff_write = cmd.valid && (cmd.data.action == cmas_pkg::ACT_WRITE);
                ctl.start_load  = cmd.valid && (cmd.data.action == cmas_pkg::ACT_START);
            end
            cmas_pkg::ST_RUN:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg < CW'(cmas_pkg::MAC_FIRST))
                begin
                    ctl.tag.op = cmas_pkg::OP_MONO;
                    ctl.tag.k  = cmas_pkg::mono_t'(5'(cnt_reg) + 5'(cmas_pkg::MONO_FIRST));
                end
                else if (cnt_reg < CW'(cmas_pkg::RADSQ_AT))
                begin
                    ctl.tag.op   = cmas_pkg::OP_MAC;
                    ctl.tag.k    = cmas_pkg::mono_t'(5'(mac_rem));
                    ctl.tag.axis = mac_axis;
                end
                else if (cnt_reg == CW'(cmas_pkg::RADSQ_AT))
                begin
                    ctl.tag.op = cmas_pkg::OP_RADSQ;
                end
                else if (cnt_reg <= CW'(cmas_pkg::SQ_LAST))
                begin
                    ctl.tag.op   = cmas_pkg::OP_SQ;
                    ctl.tag.axis = 2'(cnt_reg - CW'(cmas_pkg::SQ_FIRST));
                end
            end
            cmas_pkg::ST_DONE:
            begin
                ctl.finish      = status.out_free;
                ctl.escaped     = escape_seen_reg || status.escape;
                ctl.last        = status.escape ||
                                  ((17'(step_cnt_reg) + 17'd1) >= 17'(iter_count_reg));
                ctl.step_number = step_cnt_reg;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= cmas_pkg::ST_IDLE;
            cnt_reg          <= '0;
            step_cnt_reg     <= '0;
            iter_count_reg   <= cmas_pkg::COUNT_W'(1);
            run_finished_reg <= 1'b0;
            escape_seen_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we && (cfg_index == cmas_pkg::REG_ITERATION_COUNT))
            begin
                iter_count_reg <= cfg_data[cmas_pkg::COUNT_W-1:0];
            end
            if (ctl.start_load)
            begin
                step_cnt_reg     <= '0;
                run_finished_reg <= 1'b0;
                escape_seen_reg  <= 1'b0;
            end
            else if (ctl.finish)
            begin
                step_cnt_reg     <= step_cnt_reg + cmas_pkg::COUNT_W'(1);
                run_finished_reg <= ctl.last;
                escape_seen_reg  <= ctl.escaped;
            end
        end
    end

endmodule

// ----- design/cmas_datapath.sv -----
// cmas_datapath: shared multiplier pipeline, monomial and point registers, coefficient table
module cmas_datapath #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cmas_pkg::ctl_t                       ctl,
    output cmas_pkg::status_t                    status,
    input  cmas_pkg::in_item_t                   item,
    input  logic                                 cfg_we,
    input  logic [cmas_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cmas_pkg::RADIUS_W-1:0]        cfg_data,
    cmas_stream_if.source                        result
);

    localparam int W     = cmas_pkg::COORD_W;
    localparam int AW    = cmas_pkg::COEFF_ADDR_W;
    localparam int RND_W = 64 - FRAC_BITS;
    localparam int ACC_W = RND_W + 5;
    localparam int RR_W  = 2 * cmas_pkg::RADIUS_W;
    localparam logic signed [W-1:0] ONE  = 32'sh1 << FRAC_BITS;
    localparam logic signed [63:0]  HALF = 64'sh1 << (FRAC_BITS - 1);

    // architectural state
    logic signed [W-1:0]                cur_x_reg, cur_y_reg, cur_z_reg;
    logic [cmas_pkg::RADIUS_W-1:0]      radius_reg;
    logic [cmas_pkg::TABLE_DEPTH-1:0]   cvalid_reg;

    // working registers of one step
    logic signed [W-1:0]        mono_reg [cmas_pkg::MONO_FIRST:cmas_pkg::TERMS_PER_AXIS-1];
    logic signed [W-1:0]        nx_reg [cmas_pkg::AXES];
    logic signed [ACC_W-1:0]    acc_reg;
    logic [63:0]                norm_reg;
    logic [RR_W-1:0]            rr_reg;

    // multiplier pipeline
    cmas_pkg::mul_tag_t         tag1_reg, tag2_reg;
    logic signed [W-1:0]        a_reg, a_next;
    logic signed [W-1:0]        b_reg, b_next;
    logic                       cval_q_reg;
    logic signed [63:0]         prod_reg, prod_next;
    logic signed [W-1:0]        mult_a;
    logic signed [W-1:0]        coeff;

    // rounding and accumulation
    logic signed [63:0]         rnd_sum, rnd_shift;
    logic signed [RND_W-1:0]    rnd;
    logic signed [W-1:0]        rnd_sat;
    logic signed [ACC_W-1:0]    acc_base, sum_next;
    logic signed [W-1:0]        next_coord;

    cmas_pkg::out_item_t        out_reg;
    logic                       out_valid_reg;

    logic [AW-1:0]              ram_raddr;
    logic [W-1:0]               ram_q;
    logic                       coeff_we;

    assign coeff_we  = ctl.coeff_write && (item.coeff_index < AW'(cmas_pkg::TABLE_DEPTH));
    assign ram_raddr = AW'(ctl.tag.axis) * AW'(cmas_pkg::TERMS_PER_AXIS) + AW'(ctl.tag.k);

    cmas_ram #(
        .WIDTH (W),
        .DEPTH (cmas_pkg::TABLE_DEPTH)
    ) u_coeff_ram (
        .clk   (clk),
        .we    (coeff_we),
        .waddr (item.coeff_index),
        .wdata (item.coeff_value),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // issue stage: operand selection
    always_comb
    begin
        a_next = '0;
        b_next = '0;
        case (ctl.tag.op)
            cmas_pkg::OP_MONO:
            begin
                case (ctl.tag.k)
                    cmas_pkg::MONO_XY:  begin a_next = cur_x_reg; b_next = cur_y_reg; end
                    cmas_pkg::MONO_XZ:  begin a_next = cur_x_reg; b_next = cur_z_reg; end
                    cmas_pkg::MONO_YZ:  begin a_next = cur_y_reg; b_next = cur_z_reg; end
                    cmas_pkg::MONO_XX:  begin a_next = cur_x_reg; b_next = cur_x_reg; end
                    cmas_pkg::MONO_YY:  begin a_next = cur_y_reg; b_next = cur_y_reg; end
                    cmas_pkg::MONO_ZZ:  begin a_next = cur_z_reg; b_next = cur_z_reg; end
                    cmas_pkg::MONO_XYZ:
                    begin
                        a_next = mono_reg[5'(cmas_pkg::MONO_XY)];
                        b_next = cur_z_reg;
                    end
                    cmas_pkg::MONO_XXY:
                    begin
                        a_next = mono_reg[5'(cmas_pkg::MONO_XX)];
                        b_next = cur_y_reg;
                    end
                    cmas_pkg::MONO_XXZ:
                    begin
                        a_next = mono_reg[5'(cmas_pkg::MONO_XX)];
                        b_next = cur_z_reg;
                    end
                    cmas_pkg::MONO_YYX:
                    begin
                        a_next = mono_reg[5'(cmas_pkg::MONO_YY)];
                        b_next = cur_x_reg;
                    end
                    cmas_pkg::MONO_YYZ:
                    begin
                        a_next = mono_reg[5'(cmas_pkg::MONO_YY)];
                        b_next = cur_z_reg;
                    end
                    cmas_pkg::MONO_ZZX:
                    begin
                        a_next = mono_reg[5'(cmas_pkg::MONO_ZZ)];
                        b_next = cur_x_reg;
                    end
                    cmas_pkg::MONO_ZZY:
                    begin
                        a_next = mono_reg[5'(cmas_pkg::MONO_ZZ)];
                        b_next = cur_y_reg;
                    end
                    cmas_pkg::MONO_XXX:
                    begin
                        a_next = mono_reg[5'(cmas_pkg::MONO_XX)];
                        b_next = cur_x_reg;
                    end
                    cmas_pkg::MONO_YYY:
                    begin
                        a_next = mono_reg[5'(cmas_pkg::MONO_YY)];
                        b_next = cur_y_reg;
                    end
                    cmas_pkg::MONO_ZZZ:
                    begin
                        a_next = mono_reg[5'(cmas_pkg::MONO_ZZ)];
                        b_next = cur_z_reg;
                    end
                    default:
                    begin
                        a_next = '0;
                        b_next = '0;
                    end
                endcase
            end
            cmas_pkg::OP_MAC:
            begin
                // coefficient comes from the table one stage later
                case (ctl.tag.k)
                    cmas_pkg::MONO_ONE: b_next = ONE;
                    cmas_pkg::MONO_X:   b_next = cur_x_reg;
                    cmas_pkg::MONO_Y:   b_next = cur_y_reg;
                    cmas_pkg::MONO_Z:   b_next = cur_z_reg;
                    default:            b_next = mono_reg[5'(ctl.tag.k)];
                endcase
            end
            cmas_pkg::OP_RADSQ:
            begin
                a_next = W'(radius_reg);
                b_next = W'(radius_reg);
            end
            cmas_pkg::OP_SQ:
            begin
                a_next = nx_reg[ctl.tag.axis];
                b_next = nx_reg[ctl.tag.axis];
            end
            default:
            begin
                a_next = '0;
                b_next = '0;
            end
        endcase
    end

    // multiply stage; never-written coefficients read as zero
    assign coeff     = cval_q_reg ? $signed(ram_q) : '0;
    assign mult_a    = (tag1_reg.op == cmas_pkg::OP_MAC) ? coeff : a_reg;
    assign prod_next = mult_a * b_reg;

    // round half up, then saturate or accumulate
    assign rnd_sum    = prod_reg + HALF;
    assign rnd_shift  = rnd_sum >>> FRAC_BITS;
    assign rnd        = rnd_shift[RND_W-1:0];
    assign rnd_sat    = cmas_pkg::sat32(64'(rnd));
    assign acc_base   = (tag2_reg.k == cmas_pkg::MONO_ONE) ? '0 : acc_reg;
    assign sum_next   = acc_base + ACC_W'(rnd);
    assign next_coord = cmas_pkg::sat32(64'(sum_next));

    assign status.escape   = (radius_reg != '0) && (norm_reg > 64'(rr_reg));
    assign status.out_free = !out_valid_reg || result.ready;

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            cur_z_reg     <= '0;
            radius_reg    <= '0;
            cvalid_reg    <= '0;
            tag1_reg      <= '0;
            tag2_reg      <= '0;
            cval_q_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tag1_reg   <= ctl.tag;
            tag2_reg   <= tag1_reg;
            cval_q_reg <= cvalid_reg[ram_raddr];
            if (cfg_we && (cfg_index == cmas_pkg::REG_ESCAPE_RADIUS))
            begin
                radius_reg <= cfg_data;
            end
            if (coeff_we)
            begin
                cvalid_reg[item.coeff_index] <= 1'b1;
            end
            if (ctl.start_load)
            begin
                cur_x_reg <= item.start_x;
                cur_y_reg <= item.start_y;
                cur_z_reg <= item.start_z;
            end
            else if (ctl.finish)
            begin
                cur_x_reg <= nx_reg[0];
                cur_y_reg <= nx_reg[1];
                cur_z_reg <= nx_reg[2];
            end
            if (ctl.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        case (tag2_reg.op)
            cmas_pkg::OP_MONO:
            begin
                mono_reg[5'(tag2_reg.k)] <= rnd_sat;
            end
            cmas_pkg::OP_MAC:
            begin
                acc_reg <= sum_next;
                if (tag2_reg.k == cmas_pkg::MONO_ZZZ)
                begin
                    nx_reg[tag2_reg.axis] <= next_coord;
                end
            end
            cmas_pkg::OP_RADSQ:
            begin
                rr_reg <= prod_reg[RR_W-1:0];
            end
            cmas_pkg::OP_SQ:
            begin
                norm_reg <= ((tag2_reg.axis == 2'd0) ? 64'd0 : norm_reg) + $unsigned(prod_reg);
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
        if (ctl.finish)
        begin
            out_reg.point_x     <= nx_reg[0];
            out_reg.point_y     <= nx_reg[1];
            out_reg.point_z     <= nx_reg[2];
            out_reg.escaped     <= ctl.escaped;
            out_reg.last        <= ctl.last;
            out_reg.step_number <= ctl.step_number;
        end
    end

endmodule

// ----- design/cubic_map_attractor_step.sv -----
// cubic_map_attractor_step: top level, controller plus multiplier datapath
// coefficient writes and start items are accepted in the idle state
// a step item runs the whole multiplier schedule before its result beat is registered; the next item is taken
// only after that run, and later if the previous result beat has not been taken by then
// the schedule runs on one shared 32x32 multiplier: 16 monomials, 60 coefficient products,
// the radius square and three coordinate squares, plus a three-stage pipeline drain
// reset: coefficients read as zero, point at the origin, iteration count 1, escape check off
module cubic_map_attractor_step #(
    parameter int FRAC_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    cmas_stream_if.sink                          cmd,
    cmas_stream_if.source                        result,
    input  logic                                 cfg_we,
    input  logic [cmas_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cmas_pkg::RADIUS_W-1:0]        cfg_data
);

    cmas_pkg::ctl_t     ctl;
    cmas_pkg::status_t  status;

    cmas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .ctl       (ctl)
    );

    cmas_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .status    (status),
        .item      (cmd.data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

endmodule
